/* rtl/core/bdq_pkg.sv */
// bounded deque with search: shared types, request and status codes, sizes
// used by bdq_ctrl, bdq_dpath and bounded_deque_with_search_core
// no dependencies
`default_nettype none

package bdq_pkg;

	// storage size; slot arithmetic wraps by truncation, so DEPTH is a power of two
	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH) + 1;

	// request codes
	localparam logic [2:0] REQ_INS_FRONT = 3'd0;
	localparam logic [2:0] REQ_INS_BACK  = 3'd1;
	localparam logic [2:0] REQ_REM_FRONT = 3'd2;
	localparam logic [2:0] REQ_REM_BACK  = 3'd3;
	localparam logic [2:0] REQ_SEARCH    = 3'd4;
	localparam logic [2:0] REQ_CLEAR     = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// request payload
	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value;
	} req_t;

	// result payload
	typedef struct packed {
		logic signed [31:0] result_value;
		logic               found;
		logic [3:0]         position;
		logic [1:0]         status;
		logic [4:0]         entry_count;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic take_rd;
		logic srch_init;
		logic srch_step;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_search;
		logic rd_pending;
		logic srch_hit;
		logic srch_miss;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/core/bdq_ctrl.sv */
// bounded deque with search: request sequencer
// depends on bdq_pkg (cmd_t, sts_t)
`default_nettype none

module bdq_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire bdq_pkg::sts_t sts,
	output bdq_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_SEARCH = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// one request at a time
	assign req_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_search) begin
					cmd.srch_init = 1'b1;
					state_nxt     = S_SEARCH;
				end else begin
					cmd.exec  = 1'b1;
					state_nxt = sts.rd_pending ? S_RDWAIT : S_EMIT;
				end
			end
			S_RDWAIT: begin
				cmd.take_rd = 1'b1;
				state_nxt   = S_EMIT;
			end
			S_SEARCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_hit || sts.srch_miss) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/bdq_dpath.sv */
// bounded deque with search: entry store, head and count, search scan, result register
// depends on bdq_pkg (types, codes, sizes)
`default_nettype none

module bdq_dpath (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bdq_pkg::req_t req,
	output bdq_pkg::rsp_t    rsp,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	input  wire bdq_pkg::cmd_t cmd,
	output bdq_pkg::sts_t    sts
);

	logic [31:0]                 mem [bdq_pkg::DEPTH];
	bdq_pkg::req_t               req_q;
	logic [bdq_pkg::ADDR_W-1:0]  head_q;
	logic [bdq_pkg::CNT_W-1:0]   count_q;
	logic [31:0]                 rd_data_q;
	logic [bdq_pkg::CNT_W-1:0]   idx_q;
	logic [bdq_pkg::ADDR_W-1:0]  cmp_idx_q;
	logic                        cmp_vld_q;
	bdq_pkg::rsp_t               res_q;
	bdq_pkg::rsp_t               rsp_q;
	logic                        rsp_valid_q;

	logic                        full;
	logic                        empty;
	logic [bdq_pkg::ADDR_W-1:0]  head_dec;
	logic [bdq_pkg::ADDR_W-1:0]  back_slot;
	logic [bdq_pkg::ADDR_W-1:0]  last_slot;
	logic [bdq_pkg::ADDR_W-1:0]  srch_slot;
	logic                        srch_more;
	logic                        wr_en;
	logic [bdq_pkg::ADDR_W-1:0]  wr_addr;
	logic                        rd_en;
	logic [bdq_pkg::ADDR_W-1:0]  rd_addr;
	logic [bdq_pkg::ADDR_W-1:0]  head_nxt;
	logic [bdq_pkg::CNT_W-1:0]   count_nxt;
	logic [1:0]                  status_nxt;
	logic                        hit;

	// occupancy and slot addresses
	assign full      = (count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign head_dec  = head_q - 1'b1;
	assign back_slot = head_q + count_q[bdq_pkg::ADDR_W-1:0];
	assign last_slot = back_slot - 1'b1;
	assign srch_slot = head_q + idx_q[bdq_pkg::ADDR_W-1:0];
	assign srch_more = (idx_q != count_q);
	assign hit       = cmp_vld_q && (rd_data_q == req_q.value);

	// status to controller
	assign sts.is_search  = (req_q.req_type == bdq_pkg::REQ_SEARCH);
	assign sts.rd_pending = ((req_q.req_type == bdq_pkg::REQ_REM_FRONT) ||
	                         (req_q.req_type == bdq_pkg::REQ_REM_BACK)) && !empty;
	assign sts.srch_hit   = hit;
	assign sts.srch_miss  = !hit && !srch_more;
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	// request execution: store access, pointer update, status
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = head_dec;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		head_nxt   = head_q;
		count_nxt  = count_q;
		status_nxt = bdq_pkg::STAT_OK;
		if (cmd.exec) begin
			case (req_q.req_type)
				bdq_pkg::REQ_INS_FRONT: begin
					if (full) begin
						status_nxt = bdq_pkg::STAT_FULL;
					end else begin
						wr_en     = 1'b1;
						wr_addr   = head_dec;
						head_nxt  = head_dec;
						count_nxt = count_q + 1'b1;
					end
				end
				bdq_pkg::REQ_INS_BACK: begin
					if (full) begin
						status_nxt = bdq_pkg::STAT_FULL;
					end else begin
						wr_en     = 1'b1;
						wr_addr   = back_slot;
						count_nxt = count_q + 1'b1;
					end
				end
				bdq_pkg::REQ_REM_FRONT: begin
					if (empty) begin
						status_nxt = bdq_pkg::STAT_EMPTY;
					end else begin
						rd_en     = 1'b1;
						rd_addr   = head_q;
						head_nxt  = head_q + 1'b1;
						count_nxt = count_q - 1'b1;
					end
				end
				bdq_pkg::REQ_REM_BACK: begin
					if (empty) begin
						status_nxt = bdq_pkg::STAT_EMPTY;
					end else begin
						rd_en     = 1'b1;
						rd_addr   = last_slot;
						count_nxt = count_q - 1'b1;
					end
				end
				bdq_pkg::REQ_CLEAR: begin
					head_nxt  = '0;
					count_nxt = '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.srch_step && srch_more) begin
			rd_en   = 1'b1;
			rd_addr = srch_slot;
		end
	end

	// entry store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= req_q.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// head, count, search scan control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			cmp_idx_q   <= '0;
			cmp_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				head_q  <= head_nxt;
				count_q <= count_nxt;
			end
			if (cmd.srch_init) begin
				idx_q     <= '0;
				cmp_vld_q <= 1'b0;
			end else if (cmd.srch_step) begin
				if (srch_more) begin
					cmp_idx_q <= idx_q[bdq_pkg::ADDR_W-1:0];
					idx_q     <= idx_q + 1'b1;
					cmp_vld_q <= 1'b1;
				end else begin
					cmp_vld_q <= 1'b0;
				end
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request capture, pending result and output register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			res_q.result_value <= '0;
			res_q.found        <= 1'b0;
			res_q.position     <= '0;
			res_q.status       <= status_nxt;
			res_q.entry_count  <= 5'(count_nxt);
		end
		if (cmd.take_rd) begin
			res_q.result_value <= rd_data_q;
		end
		if (cmd.srch_init) begin
			res_q.result_value <= '0;
			res_q.found        <= 1'b0;
			res_q.position     <= '0;
			res_q.status       <= bdq_pkg::STAT_OK;
			res_q.entry_count  <= 5'(count_q);
		end else if (cmd.srch_step && hit) begin
			res_q.found    <= 1'b1;
			res_q.position <= 4'(cmp_idx_q);
		end
		if (cmd.emit) begin
			rsp_q <= res_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* rtl/core/bounded_deque_with_search_core.sv */
// bounded deque with search, top level: one request in, one result out
// insert, clear, refused and unknown requests pass decode then emit; a removal adds a
// store read wait, and a search scans entries until the first match or the last entry
// one request in flight; the store's single read port sets the search time, a new request
// is taken the cycle after its predecessor's result enters the output register
// reset clears head, count and the sequencer; stored entries are left undefined
`default_nettype none

module bounded_deque_with_search_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire bdq_pkg::req_t req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output bdq_pkg::rsp_t    rsp
);

	bdq_pkg::cmd_t cmd;
	bdq_pkg::sts_t sts;

	// sequencer
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store and result path
	bdq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

/* bench/bounded_deque_with_search_core_test.sv */
// self-checking bench for bounded_deque_with_search_core: directed and random requests with
// a cycle-free deque predictor, bursty sender and stalling receiver
// depends on bdq_pkg and the core RTL
`timescale 1ns / 1ps

module bounded_deque_with_search_core_test;
	import bdq_pkg::*;

	// request codes the block decodes as no operation
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;
	localparam int RANDOM_REQS = 800;
	localparam int POOL_SIZE   = 8;

	logic clk;
	logic arst_n;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bounded_deque_with_search_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow copy of the deque
	logic signed [31:0] shadow_slots [DEPTH];
	logic [ADDR_W-1:0]  shadow_head = '0;
	logic [CNT_W-1:0]   shadow_count = '0;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int   mismatch_cnt = 0;
	int   rsp_checked = 0;
	int   full_refusals = 0;
	int   empty_refusals = 0;
	int   search_hits = 0;

	// apply one request to the shadow deque and return the result it should give
	function automatic rsp_t deque_apply(req_t r);
		rsp_t o;
		logic [ADDR_W-1:0] slot;
		o = '0;
		case (r.req_type)
			REQ_INS_FRONT, REQ_INS_BACK: begin
				if (shadow_count == DEPTH) begin
					o.status = STAT_FULL;
					full_refusals++;
				end else begin
					if (r.req_type == REQ_INS_FRONT) begin
						shadow_head = shadow_head - 1'b1;
						slot = shadow_head;
					end else begin
						slot = shadow_head + shadow_count[ADDR_W-1:0];
					end
					shadow_slots[slot] = r.value;
					shadow_count = shadow_count + 1'b1;
				end
			end
			REQ_REM_FRONT, REQ_REM_BACK: begin
				if (shadow_count == 0) begin
					o.status = STAT_EMPTY;
					empty_refusals++;
				end else begin
					if (r.req_type == REQ_REM_FRONT) begin
						slot = shadow_head;
						shadow_head = shadow_head + 1'b1;
					end else begin
						slot = shadow_head + shadow_count[ADDR_W-1:0] - 1'b1;
					end
					o.result_value = shadow_slots[slot];
					shadow_count = shadow_count - 1'b1;
				end
			end
			REQ_SEARCH: begin
				// first match from the front wins
				for (int i = 0; i < shadow_count && !o.found; i++) begin
					slot = shadow_head + i[ADDR_W-1:0];
					if (shadow_slots[slot] == r.value) begin
						o.found = 1'b1;
						o.position = i[3:0];
					end
				end
				if (o.found)
					search_hits++;
			end
			REQ_CLEAR: begin
				shadow_head = '0;
				shadow_count = '0;
			end
			default: ;
		endcase
		o.entry_count = shadow_count;
		return o;
	endfunction

	// sender: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsps.push_back(deque_apply(pending_reqs.pop_front()));
			// a stalled transfer holds its payload
			if (!(req_valid && req_stall)) begin
				if (gap_left != 0) begin
					req_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() != 0) begin
					req_valid <= 1'b1;
					req <= pending_reqs[0];
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: randomly chosen stall patterns, one long hold-off
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	int rx_count = 0;
	logic held_once = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			hold_left <= 0;
			rx_count <= 0;
			held_once <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				rx_count <= rx_count + 1;
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!held_once && rx_count >= 150) begin
				// long hold-off while the sender keeps offering requests
				rsp_stall <= 1'b1;
				hold_left <= 400;
				held_once <= 1'b1;
			end else if (mode_left == 0) begin
				rsp_stall <= 1'b0;
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 300);
			end else begin
				mode_left <= mode_left - 1;
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= (mode_left % 5 < 2);
				endcase
			end
		end
	end

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endfunction

	// monitor: each result transfer against the oldest expectation
	rsp_t want_rsp;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$error("result with no request outstanding: %p", rsp);
				mismatch_cnt++;
			end else begin
				want_rsp = expected_rsps.pop_front();
				check_field("result_value", want_rsp.result_value, rsp.result_value);
				check_field("found", want_rsp.found, rsp.found);
				check_field("position", want_rsp.position, rsp.position);
				check_field("status", want_rsp.status, rsp.status);
				check_field("entry_count", want_rsp.entry_count, rsp.entry_count);
				rsp_checked++;
			end
		end
	end

	function automatic void add_req(logic [2:0] kind, logic signed [31:0] v);
		req_t r;
		r.req_type = kind;
		r.value = v;
		pending_reqs.push_back(r);
	endfunction

	// stimulus and end of run
	logic signed [31:0] value_pool [POOL_SIZE];
	logic signed [31:0] v;
	logic signed [31:0] last_back;
	int phase_left;
	int ins_pct;
	int roll;

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty store refusals, search on empty, spare codes
		add_req(REQ_REM_FRONT, $urandom);
		add_req(REQ_REM_BACK, $urandom);
		add_req(REQ_SEARCH, 32'sd0);
		add_req(REQ_SPARE_6, $urandom);
		add_req(REQ_SPARE_7, $urandom);
		// fill from both ends with the value extremes, wrapping the head
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0: v = 32'sh7fffffff;
				1: v = 32'sh80000000;
				2: v = 32'sd0;
				3: v = -32'sd1;
				default: v = $urandom;
			endcase
			if (i == DEPTH - 2)
				last_back = v;
			add_req((i % 2) ? REQ_INS_FRONT : REQ_INS_BACK, v);
		end
		// full refusals, match at the last position, both removals, clear
		add_req(REQ_INS_FRONT, $urandom);
		add_req(REQ_INS_BACK, $urandom);
		add_req(REQ_SEARCH, last_back);
		add_req(REQ_REM_FRONT, $urandom);
		add_req(REQ_REM_BACK, $urandom);
		add_req(REQ_CLEAR, $urandom);

		// sender pauses until the directed part has fully drained
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
		@(negedge clk);

		// small value pool so duplicates and search hits are common
		value_pool[0] = 32'sh7fffffff;
		value_pool[1] = 32'sh80000000;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		phase_left = 0;
		ins_pct = 50;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			// fill, drain and balanced phases push the count to both limits
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 60);
				case ($urandom_range(0, 2))
					0: ins_pct = 85;
					1: ins_pct = 15;
					default: ins_pct = 50;
				endcase
			end
			phase_left--;
			v = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
				: $urandom;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				add_req(REQ_CLEAR, v);
			else if (roll < 4)
				add_req($urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6, v);
			else if (roll < 34)
				add_req(REQ_SEARCH, v);
			else if ($urandom_range(0, 99) < ins_pct)
				add_req($urandom_range(0, 1) ? REQ_INS_BACK : REQ_INS_FRONT, v);
			else
				add_req($urandom_range(0, 1) ? REQ_REM_BACK : REQ_REM_FRONT, v);

			// a second full drain half way through
			if (n == RANDOM_REQS / 2) begin
				while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
					@(posedge clk);
				@(negedge clk);
			end
		end

		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("checked %0d results: %0d full refusals, %0d empty refusals, %0d search hits",
			rsp_checked, full_refusals, empty_refusals, search_hits);
		if (mismatch_cnt == 0 && expected_rsps.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// timeout
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
